// ----- rtl/bb3_pkg.sv -----
// bb3_pkg: shared constants and types for the 3x3 box blur core.
// Used by every module under rtl/; depends on nothing.
`default_nettype none

package bb3_pkg;

   localparam int IMAGE_SIZE = 256;
   localparam int CNT_W      = $clog2(IMAGE_SIZE);
   localparam int PIX_W      = 8;
   localparam int LINE_CELLS = 2 * IMAGE_SIZE;

   // nine 8-bit values sum to at most 2295
   localparam int SUM_W      = 12;
   // floor(sum / 9) == (sum * 7282) >> 16 for every sum below 2296
   localparam int DIV_SHIFT  = 16;
   localparam int RECIP_W    = 13;
   localparam logic [RECIP_W-1:0] DIV_RECIP = 13'd7282;

   typedef struct packed {
      logic             hit;
      logic [PIX_W-1:0] row;
      logic [PIX_W-1:0] col;
      logic             last;
   } bb3_tag_type;

endpackage

`default_nettype wire

// ----- rtl/bb3_cell.sv -----
// bb3_cell: one pixel slot of the line buffer chain.
// Standalone; uses bb3_pkg for the pixel width.
`default_nettype none

module bb3_cell (
   input  wire logic                      clock,
   input  wire logic                      shift_en,
   input  wire logic [bb3_pkg::PIX_W-1:0] pix_d,
   output logic      [bb3_pkg::PIX_W-1:0] pix_q
);

   logic [bb3_pkg::PIX_W-1:0] pix_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         pix_ff <= pix_d;
      end
   end

   assign pix_q = pix_ff;

endmodule

`default_nettype wire

// ----- rtl/bb3_window.sv -----
// bb3_window: 3x3 window columns, nine-value sum, divide by nine and result register.
// Depends on bb3_pkg.
`default_nettype none

module bb3_window (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      shift_en,
   input  wire logic [bb3_pkg::PIX_W-1:0] bot_pix,
   input  wire logic [bb3_pkg::PIX_W-1:0] mid_pix,
   input  wire logic [bb3_pkg::PIX_W-1:0] top_pix,
   input  wire bb3_pkg::bb3_tag_type      tag,
   output logic                           in_stall,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [bb3_pkg::PIX_W-1:0]      rsp_blurred_pixel,
   output logic [bb3_pkg::PIX_W-1:0]      rsp_center_row,
   output logic [bb3_pkg::PIX_W-1:0]      rsp_center_col,
   output logic                           rsp_frame_done
);

   localparam int PROD_W = bb3_pkg::SUM_W + bb3_pkg::RECIP_W;

   // columns c-1 (near) and c-2 (far)
   logic [bb3_pkg::PIX_W-1:0] near_top_ff, near_mid_ff, near_bot_ff;
   logic [bb3_pkg::PIX_W-1:0] far_top_ff, far_mid_ff, far_bot_ff;

   logic                      s1_valid_ff, s1_valid_in;
   logic [bb3_pkg::SUM_W-1:0] s1_sum_ff, s1_sum_in;
   bb3_pkg::bb3_tag_type      s1_tag_ff;

   logic                      rsp_valid_ff;
   logic [bb3_pkg::PIX_W-1:0] pix_ff, pix_in;
   logic [bb3_pkg::PIX_W-1:0] row_ff, col_ff;
   logic                      done_ff;

   logic                      out_en, s1_en;
   logic [PROD_W-1:0]         prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         near_top_ff <= '0;
         near_mid_ff <= '0;
         near_bot_ff <= '0;
         far_top_ff  <= '0;
         far_mid_ff  <= '0;
         far_bot_ff  <= '0;
      end else if (shift_en) begin
         far_top_ff  <= near_top_ff;
         far_mid_ff  <= near_mid_ff;
         far_bot_ff  <= near_bot_ff;
         near_top_ff <= top_pix;
         near_mid_ff <= mid_pix;
         near_bot_ff <= bot_pix;
      end
   end

   always_comb begin
      s1_sum_in = bb3_pkg::SUM_W'(top_pix) + bb3_pkg::SUM_W'(mid_pix)
                + bb3_pkg::SUM_W'(bot_pix)
                + bb3_pkg::SUM_W'(near_top_ff) + bb3_pkg::SUM_W'(near_mid_ff)
                + bb3_pkg::SUM_W'(near_bot_ff)
                + bb3_pkg::SUM_W'(far_top_ff) + bb3_pkg::SUM_W'(far_mid_ff)
                + bb3_pkg::SUM_W'(far_bot_ff);
      s1_valid_in = shift_en && tag.hit;
   end

   // advance the output slot when it is empty or being taken; stage 1 fills bubbles
   assign out_en   = !rsp_valid_ff || !rsp_stall;
   assign s1_en    = !s1_valid_ff || out_en;
   assign in_stall = !s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_sum_ff <= s1_sum_in;
         s1_tag_ff <= tag;
      end
   end

   assign prod   = PROD_W'(s1_sum_ff) * PROD_W'(bb3_pkg::DIV_RECIP);
   assign pix_in = prod[bb3_pkg::DIV_SHIFT +: bb3_pkg::PIX_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         pix_ff  <= pix_in;
         row_ff  <= s1_tag_ff.row;
         col_ff  <= s1_tag_ff.col;
         done_ff <= s1_tag_ff.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_blurred_pixel = pix_ff;
   assign rsp_center_row    = row_ff;
   assign rsp_center_col    = col_ff;
   assign rsp_frame_done    = done_ff;

endmodule

`default_nettype wire

// ----- rtl/box_blur_3x3_gray_core.sv -----
// box_blur_3x3_gray_core: streaming 3x3 mean filter over a square grayscale frame.
// Depends on bb3_pkg, bb3_cell and bb3_window.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------------
//   req     | req_valid/req_stall  | req_pixel_in
//   rsp     | rsp_valid/rsp_stall  | rsp_blurred_pixel, rsp_center_row/col, rsp_frame_done
//
// One pixel per cycle while requests are not stalled. The sum stage registers the
// nine-value sum; the result register takes the reciprocal multiply that divides by nine.
// Line buffers are a chain of 2*IMAGE_SIZE pixel cells that shift once per request.
// Reset clears the counters, window and valid bits; cell contents stay undefined.
// A stalled result holds; one more result fits in the sum stage, then requests stall.
`default_nettype none

module box_blur_3x3_gray_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [bb3_pkg::PIX_W-1:0] req_pixel_in,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [bb3_pkg::PIX_W-1:0]      rsp_blurred_pixel,
   output logic [bb3_pkg::PIX_W-1:0]      rsp_center_row,
   output logic [bb3_pkg::PIX_W-1:0]      rsp_center_col,
   output logic                           rsp_frame_done
);

   localparam logic [bb3_pkg::CNT_W-1:0] LAST_POS = bb3_pkg::CNT_W'(bb3_pkg::IMAGE_SIZE - 1);
   localparam logic [bb3_pkg::CNT_W-1:0] ONE_POS  = bb3_pkg::CNT_W'(1);
   localparam logic [bb3_pkg::CNT_W-1:0] TWO_POS  = bb3_pkg::CNT_W'(2);

   logic [bb3_pkg::CNT_W-1:0] col_ff, col_in;
   logic [bb3_pkg::CNT_W-1:0] row_ff, row_in;
   logic                      accept;
   logic                      in_stall;
   bb3_pkg::bb3_tag_type      tag;

   logic [bb3_pkg::PIX_W-1:0] chain_q [bb3_pkg::LINE_CELLS];

   assign req_stall = in_stall;
   assign accept    = req_valid && !in_stall;

   // first cell takes the new pixel, each other cell its left neighbor
   genvar i;
   generate
      for (i = 0; i < bb3_pkg::LINE_CELLS; i++) begin : g_cell
         if (i == 0) begin : g_head
            bb3_cell u_cell (
               .clock    (clock),
               .shift_en (accept),
               .pix_d    (req_pixel_in),
               .pix_q    (chain_q[i])
            );
         end else begin : g_body
            bb3_cell u_cell (
               .clock    (clock),
               .shift_en (accept),
               .pix_d    (chain_q[i-1]),
               .pix_q    (chain_q[i])
            );
         end
      end
   endgenerate

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_ff == LAST_POS) begin
            col_in = '0;
            row_in = (row_ff == LAST_POS) ? '0 : row_ff + ONE_POS;
         end else begin
            col_in = col_ff + ONE_POS;
         end
      end
      tag.hit  = (row_ff >= TWO_POS) && (col_ff >= TWO_POS);
      tag.row  = bb3_pkg::PIX_W'(row_ff - ONE_POS);
      tag.col  = bb3_pkg::PIX_W'(col_ff - ONE_POS);
      tag.last = (row_ff == LAST_POS) && (col_ff == LAST_POS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   bb3_window u_window (
      .clock             (clock),
      .reset             (reset),
      .shift_en          (accept),
      .bot_pix           (req_pixel_in),
      .mid_pix           (chain_q[bb3_pkg::IMAGE_SIZE-1]),
      .top_pix           (chain_q[bb3_pkg::LINE_CELLS-1]),
      .tag               (tag),
      .in_stall          (in_stall),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_blurred_pixel (rsp_blurred_pixel),
      .rsp_center_row    (rsp_center_row),
      .rsp_center_col    (rsp_center_col),
      .rsp_frame_done    (rsp_frame_done)
   );

endmodule

`default_nettype wire

// ----- rtl/bb3_checker.sv -----
// bb3_checker: port-level checks for box_blur_3x3_gray_core, and its bind.
// Depends on bb3_pkg and the top level's port list.
`default_nettype none

module bb3_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_stall,
   input wire logic [bb3_pkg::PIX_W-1:0] req_pixel_in,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire logic [bb3_pkg::PIX_W-1:0] rsp_blurred_pixel,
   input wire logic [bb3_pkg::PIX_W-1:0] rsp_center_row,
   input wire logic [bb3_pkg::PIX_W-1:0] rsp_center_col,
   input wire logic                      rsp_frame_done
);

   localparam logic [bb3_pkg::PIX_W-1:0] END_POS = bb3_pkg::PIX_W'(bb3_pkg::IMAGE_SIZE - 2);

   // a held request keeps its pixel
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_pixel_in))
      else $error("stalled request changed");

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_blurred_pixel)
         && $stable(rsp_center_row) && $stable(rsp_center_col) && $stable(rsp_frame_done))
      else $error("stalled result changed");

   // input stalls only behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with no stalled result");

   // frame end flag only on the last interior position
   a_done_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_center_row == END_POS && rsp_center_col == END_POS)
      else $error("frame_done on wrong position");

   // nothing leaves right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind box_blur_3x3_gray_core bb3_checker u_bb3_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_pixel_in      (req_pixel_in),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_blurred_pixel (rsp_blurred_pixel),
   .rsp_center_row    (rsp_center_row),
   .rsp_center_col    (rsp_center_col),
   .rsp_frame_done    (rsp_frame_done)
);

`default_nettype wire

// ----- verif/box_blur_3x3_gray_core_tb.sv -----
// Self-checking testbench for box_blur_3x3_gray_core: streams the first rows of a frame,
// predicts every 3x3 window mean and compares it with the result channel.
// Depends on bb3_pkg and the RTL under rtl/.
module box_blur_3x3_gray_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IMAGE_SIZE     = bb3_pkg::IMAGE_SIZE;
   localparam int PIX_W          = bb3_pkg::PIX_W;
   localparam int HOLD_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 10;
   localparam int TOTAL_PIXELS   = 1350;

   typedef struct {
      logic [PIX_W-1:0] mean;
      logic [PIX_W-1:0] row;
      logic [PIX_W-1:0] col;
      logic             done;
   } mean_result_type;

   typedef enum int {
      STYLE_RANDOM,
      STYLE_WHITE,
      STYLE_BLACK,
      STYLE_BRIGHT,
      STYLE_DARK,
      STYLE_WALK
   } row_style_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [PIX_W-1:0] req_pixel_in = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [PIX_W-1:0] rsp_blurred_pixel;
   logic [PIX_W-1:0] rsp_center_row;
   logic [PIX_W-1:0] rsp_center_col;
   logic             rsp_frame_done;

   // pixels waiting to be offered, and window means waiting to come back
   logic [PIX_W-1:0] pixel_queue[$];
   mean_result_type  expected_means[$];

   // predictor state: the two rows above, the two previous columns, the position
   logic [PIX_W-1:0] row_above2[IMAGE_SIZE];
   logic [PIX_W-1:0] row_above1[IMAGE_SIZE];
   logic [PIX_W-1:0] window_px[6];
   int unsigned      pred_col;
   int unsigned      pred_row;

   int             send_idle_pct = 29;
   int             recv_idle_pct = 56;
   logic           hold_arm = 1'b0;
   logic           hold_taken = 1'b0;
   int             hold_left = 0;
   int             pixels_pushed = 0;
   int             pixels_taken = 0;
   int             means_checked = 0;
   int             frame_ends = 0;
   int             mismatches = 0;
   int             idle_cycles = 0;
   row_style_type  row_style = STYLE_RANDOM;

   box_blur_3x3_gray_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel_in      (req_pixel_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_blurred_pixel (rsp_blurred_pixel),
      .rsp_center_row    (rsp_center_row),
      .rsp_center_col    (rsp_center_col),
      .rsp_frame_done    (rsp_frame_done)
   );

   always #1 clock = ~clock;

   initial begin
      for (int i = 0; i < IMAGE_SIZE; i++) begin
         row_above2[i] = '0;
         row_above1[i] = '0;
      end
      for (int k = 0; k < 6; k++) begin
         window_px[k] = '0;
      end
      pred_col = 0;
      pred_row = 0;
   end

   // Advance the predictor by one pixel; queue the mean when the window is complete.
   function automatic void predict_mean(input logic [PIX_W-1:0] pix);
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      int unsigned      total;
      mean_result_type  res;
      top = row_above2[pred_col];
      mid = row_above1[pred_col];
      if (pred_row >= 2 && pred_col >= 2) begin
         total = int'(top) + int'(mid) + int'(pix);
         for (int k = 0; k < 6; k++) begin
            total += int'(window_px[k]);
         end
         res.mean = PIX_W'(total / 9);
         res.row  = PIX_W'(pred_row - 1);
         res.col  = PIX_W'(pred_col - 1);
         res.done = (pred_row == IMAGE_SIZE - 1) && (pred_col == IMAGE_SIZE - 1);
         expected_means.push_back(res);
      end
      window_px[0] = window_px[3];
      window_px[1] = window_px[4];
      window_px[2] = window_px[5];
      window_px[3] = top;
      window_px[4] = mid;
      window_px[5] = pix;
      row_above2[pred_col] = mid;
      row_above1[pred_col] = pix;
      pred_col++;
      if (pred_col >= IMAGE_SIZE) begin
         pred_col = 0;
         pred_row = (pred_row + 1 >= IMAGE_SIZE) ? 0 : pred_row + 1;
      end
   endfunction

   function automatic logic [PIX_W-1:0] make_pixel(input row_style_type style, input int col);
      logic [PIX_W-1:0] walk;
      walk = PIX_W'(1) << (col % PIX_W);
      case (style)
         STYLE_WHITE:  return '1;
         STYLE_BLACK:  return '0;
         STYLE_BRIGHT: return PIX_W'(255 - $urandom_range(7));
         STYLE_DARK:   return PIX_W'($urandom_range(7));
         STYLE_WALK:   return ((col / PIX_W) % 2 == 0) ? walk : ~walk;
         default:      return PIX_W'($urandom_range(255));
      endcase
   endfunction

   // Queue pixels in raster order; each row picks a texture so windows reach the extremes.
   task automatic push_pixels(input int count);
      int col;
      for (int i = 0; i < count; i++) begin
         col = pixels_pushed % IMAGE_SIZE;
         if (col == 0) begin
            case ($urandom_range(9))
               0:       row_style = STYLE_WHITE;
               1:       row_style = STYLE_BLACK;
               2:       row_style = STYLE_BRIGHT;
               3:       row_style = STYLE_DARK;
               4:       row_style = STYLE_WALK;
               default: row_style = STYLE_RANDOM;
            endcase
         end
         pixel_queue.push_back(make_pixel(row_style, col));
         pixels_pushed++;
      end
   endtask

   // Hold the sender until every queued pixel is taken and every mean has come back.
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pixels_taken != pixels_pushed || expected_means.size() != 0);
   endtask

   task automatic check_field(input string what, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, what, want, got);
         mismatches++;
      end
   endtask

   // Driver: advance to the next request only once the current one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid    <= 1'b1;
            req_pixel_in <= pixel_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off to back the pipeline up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_arm && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Monitor: predict on each taken request, then check each accepted result.
   always @(posedge clock) begin
      mean_result_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pixels_taken++;
            predict_mean(req_pixel_in);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_means.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual mean %0d at (%0d,%0d)",
                        $realtime, rsp_blurred_pixel, rsp_center_row, rsp_center_col);
               mismatches++;
            end else begin
               want = expected_means.pop_front();
               check_field("blurred_pixel", want.mean, rsp_blurred_pixel);
               check_field("center_row", want.row, rsp_center_row);
               check_field("center_col", want.col, rsp_center_col);
               check_field("frame_done", want.done, rsp_frame_done);
               means_checked++;
               if (rsp_frame_done) begin
                  frame_ends++;
               end
            end
         end
      end
   end

   // Watchdog: end the run if nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      logic [PIX_W-1:0] directed[$];
      // extremes and walking ones/zeros; these land on the border rows
      directed.push_back(8'h00);
      directed.push_back(8'hFF);
      for (int b = 0; b < PIX_W; b++) begin
         directed.push_back(PIX_W'(1) << b);
      end
      for (int b = 0; b < PIX_W; b++) begin
         directed.push_back(~(PIX_W'(1) << b));
      end
      directed.push_back(8'hFF);
      directed.push_back(8'h00);
      directed.push_back(8'h55);
      directed.push_back(8'hAA);
      directed.push_back(8'h7F);
      foreach (directed[i]) begin
         pixel_queue.push_back(directed[i]);
      end
      pixels_pushed = directed.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // sender idles less than the receiver; long hold-off once results flow
      @(negedge clock);
      push_pixels(700 - pixels_pushed);
      do begin
         @(negedge clock);
      end while (pixels_taken < 600);
      hold_arm = 1'b1;
      wait_drained();

      // receiver idles less than the sender
      send_idle_pct = 56;
      recv_idle_pct = 29;
      push_pixels(450);
      wait_drained();

      // no idling: stream the remaining pixels back to back
      send_idle_pct = 0;
      recv_idle_pct = 0;
      push_pixels(TOTAL_PIXELS - pixels_pushed);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Streamed %0d pixels over the first rows of a frame under three idle mixes.",
               pixels_taken);
      $display("Checked %0d window means, %0d of them flagged as frame end.",
               means_checked, frame_ends);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
